FILE: rtl/core/sfcb_pkg.sv
`timescale 1ns / 1ps
package sfcb_pkg;

    // frame layout
    localparam int WINDOW_LEN    = 25;
    localparam int CHANNEL_COUNT = 16;
    localparam int RAW_W         = 11;
    localparam int FRAME_BYTES   = 22;
    localparam logic [7:0] START_BYTE = 8'h0F;
    localparam logic [7:0] END_BYTE   = 8'h00;

    // validity patterns
    localparam logic [RAW_W-1:0] SW_HIGH  = 11'h708;
    localparam logic [RAW_W-1:0] SW_MID   = 11'h3E8;
    localparam logic [RAW_W-1:0] SW_LOW   = 11'h0C8;
    localparam logic [RAW_W-1:0] CH15_REF = 11'h400;

    // switch mapping targets
    localparam logic [11:0] MAP_HIGH = 12'h7CF;
    localparam logic [11:0] MAP_MID  = 12'h5DB;
    localparam logic [11:0] MAP_LOW  = 12'h3E7;

    localparam logic [11:0] STATE_MAX = 12'hFFF;

    // reported channels and derived widths
    localparam int REPORTED_CHANNELS = 8;
    localparam int CH_W = (REPORTED_CHANNELS > 1) ? $clog2(REPORTED_CHANNELS) : 1;

    // queue depths, powers of two
    localparam int FQ_DEPTH = 2;
    localparam int FQ_AW    = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = (OQ_DEPTH > 1) ? $clog2(OQ_DEPTH) : 1;

    // register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_UPPER      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_UPPER    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_LOWER      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_LOWER    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MESSAGE_BASE_ID = 3'd5;
    localparam int CFG_DATA_W = 28;

    typedef logic [RAW_W-1:0] t_raw;
    typedef t_raw [REPORTED_CHANNELS-1:0] t_frame;

    typedef struct packed {
        logic [10:0] split_threshold;
        logic [15:0] gain_upper;
        logic [27:0] offset_upper;
        logic [15:0] gain_lower;
        logic [27:0] offset_lower;
        logic [10:0] message_base_id;
    } t_cfg;

    typedef struct packed {
        logic [10:0] message_id;
        logic [7:0]  payload_high;
        logic [7:0]  payload_low;
        logic        last_of_frame;
    } t_msg;

    typedef enum logic [1:0] {
        KIND_SCALED,
        KIND_MAPPED,
        KIND_RAW
    } t_kind;

    function automatic t_kind chan_kind(input logic [4:0] ch);
        t_kind k;
        if (ch <= 5'd3 || ch == 5'd7) begin
            k = KIND_SCALED;
        end else if (ch <= 5'd6) begin
            k = KIND_MAPPED;
        end else begin
            k = KIND_RAW;
        end
        return k;
    endfunction

    function automatic logic [11:0] map_switch(input t_raw raw);
        logic [11:0] v;
        priority if (raw == SW_HIGH) begin
            v = MAP_HIGH;
        end else if (raw == SW_MID) begin
            v = MAP_MID;
        end else if (raw == SW_LOW) begin
            v = MAP_LOW;
        end else begin
            v = {1'b0, raw};
        end
        return v;
    endfunction

endpackage

FILE: rtl/core/sfcb_front.sv
`timescale 1ns / 1ps
module sfcb_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  logic [7:0]      i_rx_byte,
    output logic            o_full,
    output logic            o_frame_valid,
    output sfcb_pkg::t_frame o_frame,
    input  logic            i_frame_pop
);
    import sfcb_pkg::*;

    logic [7:0]   r_win [WINDOW_LEN];
    t_frame       r_fq [FQ_DEPTH];
    logic [FQ_AW-1:0] r_wp, r_rp;
    logic [FQ_AW:0]   r_cnt;

    logic accept, detect, good, fq_push;
    logic [8*FRAME_BYTES-1:0] bits;
    t_raw   all_raw [CHANNEL_COUNT];
    t_frame frame;

    assign o_full        = (r_cnt == (FQ_AW+1)'(FQ_DEPTH));
    assign o_frame_valid = (r_cnt != '0);
    assign o_frame       = r_fq[r_rp];

    always_comb begin
        accept = i_push && !o_full;
        // oldest byte after the shift is the current second byte
        detect = accept && (r_win[1] == START_BYTE) && (i_rx_byte == END_BYTE);
        for (int k = 0; k < FRAME_BYTES; k++) begin
            bits[8*k +: 8] = r_win[k+2];
        end
        for (int c = 0; c < CHANNEL_COUNT; c++) begin
            all_raw[c] = bits[RAW_W*c +: RAW_W];
        end
        for (int c = 0; c < REPORTED_CHANNELS; c++) begin
            frame[c] = all_raw[c];
        end
        good = (all_raw[5] == SW_LOW || all_raw[5] == SW_HIGH)
            && (all_raw[4] == SW_HIGH || all_raw[4] == SW_MID || all_raw[4] == SW_LOW)
            && (all_raw[8] == all_raw[9])
            && (all_raw[15] == CH15_REF);
        fq_push = detect && good;
    end

    // sliding window, cleared once a frame has been taken out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW_LEN; i++) begin
                r_win[i] <= '0;
            end
        end else if (detect) begin
            for (int i = 0; i < WINDOW_LEN; i++) begin
                r_win[i] <= '0;
            end
        end else if (accept) begin
            for (int i = 0; i < WINDOW_LEN-1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[WINDOW_LEN-1] <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fq_push) begin
            r_fq[r_wp] <= frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (fq_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_frame_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (FQ_AW+1)'(fq_push) - (FQ_AW+1)'(i_frame_pop);
        end
    end

endmodule

FILE: rtl/core/sfcb_back.sv
`timescale 1ns / 1ps
module sfcb_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sfcb_pkg::t_cfg   i_cfg,
    input  logic             i_frame_valid,
    input  sfcb_pkg::t_frame i_frame,
    output logic             o_frame_pop,
    input  logic             i_oq_full,
    output logic             o_oq_push,
    output sfcb_pkg::t_msg   o_oq_item
);
    import sfcb_pkg::*;

    localparam logic [CH_W-1:0] LAST_CH = CH_W'(REPORTED_CHANNELS - 1);

    logic adv;
    logic [CH_W-1:0] r_ch;

    // stage 1: select and multiply
    logic            r_s1_vld, r_s1_last;
    logic [CH_W-1:0] r_s1_ch;
    t_raw            r_s1_raw;
    logic            r_s1_upper;
    logic [26:0]     r_s1_prod;

    // stage 2: offset, saturate, build compare and payload values
    logic            r_s2_vld, r_s2_last;
    logic [CH_W-1:0] r_s2_ch;
    logic [11:0]     r_s2_cmp, r_s2_pay;

    logic [11:0] r_last_sent [REPORTED_CHANNELS];

    // one message held back until it is known whether it ends the frame
    logic r_pend_vld, r_pend_fin;
    t_msg r_pend;
    logic n_pend_vld, n_pend_fin;
    t_msg n_pend;

    t_raw        sel_raw;
    logic        sel_upper;
    logic [15:0] sel_gain;
    logic [28:0] sum;
    logic [12:0] scaled;
    logic [11:0] scaled_sat, cmp_v, pay_v;
    t_kind       kind;
    logic        emit;
    t_msg        new_msg;

    assign adv         = !i_oq_full;
    assign o_frame_pop = adv && i_frame_valid && (r_ch == LAST_CH);

    always_comb begin
        sel_raw   = i_frame[r_ch];
        sel_upper = ({1'b0, sel_raw} >= {1'b0, i_cfg.split_threshold});
        sel_gain  = sel_upper ? i_cfg.gain_upper : i_cfg.gain_lower;

        sum = {2'b00, r_s1_prod}
            + {1'b0, (r_s1_upper ? i_cfg.offset_upper : i_cfg.offset_lower)};
        scaled     = sum[28:16];
        scaled_sat = scaled[12] ? STATE_MAX : scaled[11:0];
        kind       = chan_kind(5'(r_s1_ch));
        unique case (kind)
            KIND_SCALED: begin
                cmp_v = scaled_sat;
                pay_v = scaled_sat;
            end
            KIND_MAPPED: begin
                cmp_v = {1'b0, r_s1_raw};
                pay_v = map_switch(r_s1_raw);
            end
            default: begin
                cmp_v = {1'b0, r_s1_raw};
                pay_v = {1'b0, r_s1_raw};
            end
        endcase
    end

    always_comb begin
        emit = r_s2_vld && (r_s2_cmp != r_last_sent[r_s2_ch]);
        new_msg.message_id    = i_cfg.message_base_id + 11'(r_s2_ch);
        new_msg.payload_high  = {4'b0000, r_s2_pay[11:8]};
        new_msg.payload_low   = r_s2_pay[7:0];
        new_msg.last_of_frame = 1'b0;

        o_oq_push  = 1'b0;
        o_oq_item  = r_pend;
        n_pend_vld = r_pend_vld;
        n_pend_fin = r_pend_fin;
        n_pend     = r_pend;
        if (adv) begin
            priority if (r_pend_vld && r_pend_fin) begin
                o_oq_push = 1'b1;
                o_oq_item.last_of_frame = 1'b1;
                n_pend_vld = emit;
                n_pend_fin = emit && r_s2_last;
                n_pend     = new_msg;
            end else if (emit) begin
                o_oq_push  = r_pend_vld;
                n_pend_vld = 1'b1;
                n_pend_fin = r_s2_last;
                n_pend     = new_msg;
            end else if (r_s2_vld && r_s2_last && r_pend_vld) begin
                o_oq_push = 1'b1;
                o_oq_item.last_of_frame = 1'b1;
                n_pend_vld = 1'b0;
                n_pend_fin = 1'b0;
            end else begin
                n_pend_vld = r_pend_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch       <= '0;
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_pend_fin <= 1'b0;
            for (int i = 0; i < REPORTED_CHANNELS; i++) begin
                r_last_sent[i] <= '0;
            end
        end else if (adv) begin
            if (i_frame_valid) begin
                r_ch <= (r_ch == LAST_CH) ? '0 : r_ch + 1'b1;
            end
            r_s1_vld   <= i_frame_valid;
            r_s2_vld   <= r_s1_vld;
            r_pend_vld <= n_pend_vld;
            r_pend_fin <= n_pend_fin;
            if (emit) begin
                r_last_sent[r_s2_ch] <= r_s2_cmp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_ch    <= r_ch;
            r_s1_last  <= (r_ch == LAST_CH);
            r_s1_raw   <= sel_raw;
            r_s1_upper <= sel_upper;
            r_s1_prod  <= 27'(sel_raw) * 27'(sel_gain);
            r_s2_ch    <= r_s1_ch;
            r_s2_last  <= r_s1_last;
            r_s2_cmp   <= cmp_v;
            r_s2_pay   <= pay_v;
            r_pend     <= n_pend;
        end
    end

endmodule

FILE: rtl/core/sfcb_out_queue.sv
`timescale 1ns / 1ps
module sfcb_out_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  sfcb_pkg::t_msg         i_item,
    output logic                   o_full,
    output logic                   o_empty,
    output sfcb_pkg::t_msg         o_item,
    input  logic                   i_pop,
    output logic [sfcb_pkg::OQ_AW:0] o_count
);
    import sfcb_pkg::*;

    t_msg r_mem [OQ_DEPTH];
    logic [OQ_AW-1:0] r_wp, r_rp;
    logic [OQ_AW:0]   r_cnt;
    logic do_pop;

    assign o_full  = (r_cnt == (OQ_AW+1)'(OQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rp];
    assign o_count = r_cnt;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (OQ_AW+1)'(i_push) - (OQ_AW+1)'(do_pop);
        end
    end

endmodule

FILE: rtl/core/sbus_frame_to_can_bridge.sv
`timescale 1ns / 1ps
// serial frame to message bridge: received bytes go in one per cycle through push/full, while
// full is low, and slide through a 25-byte window; when the oldest byte is the start marker and
// the newest is zero, the sixteen 11-bit channels are unpacked, the frame is checked and the
// window cleared. a good frame waits in a two-entry frame queue; the back end takes one channel
// per cycle, unless the result queue is full, through a three-stage pipe (gain multiply, offset
// add with saturation, compare against the value last sent) and every changed channel among the
// first eight leaves as one item on the result side, in channel order, with last_of_frame on the
// final one. each item is held in the pipe until the next changed channel or the end of the
// frame is seen. with no stalls the back end finishes a frame before the next one is complete,
// so full rises only when pop holds results back long enough for two checked frames to pile up
// in the frame queue. the config port is always ready; write it only while the bridge is idle.
module sbus_frame_to_can_bridge (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte side
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    // message side
    output logic        empty,
    input  logic        pop,
    output logic [10:0] o_message_id,
    output logic [7:0]  o_payload_high,
    output logic [7:0]  o_payload_low,
    output logic        o_last_of_frame,
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [sfcb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sfcb_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sfcb_pkg::*;

    t_cfg   r_cfg;
    logic   frame_valid, frame_pop;
    t_frame frame;
    logic   oq_full, oq_push;
    t_msg   oq_in, oq_out;
    logic [OQ_AW:0] oq_count;
    logic   cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    // config registers, bits above each width dropped, unknown index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.split_threshold <= 11'd1000;
            r_cfg.gain_upper      <= 16'd40878;
            r_cfg.offset_upper    <= 28'd57425920;
            r_cfg.gain_lower      <= 16'd41042;
            r_cfg.offset_lower    <= 28'd57262080;
            r_cfg.message_base_id <= 11'd16;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_SPLIT_THRESHOLD: r_cfg.split_threshold <= i_cfg_data[10:0];
                CFG_GAIN_UPPER:      r_cfg.gain_upper      <= i_cfg_data[15:0];
                CFG_OFFSET_UPPER:    r_cfg.offset_upper    <= i_cfg_data[27:0];
                CFG_GAIN_LOWER:      r_cfg.gain_lower      <= i_cfg_data[15:0];
                CFG_OFFSET_LOWER:    r_cfg.offset_lower    <= i_cfg_data[27:0];
                CFG_MESSAGE_BASE_ID: r_cfg.message_base_id <= i_cfg_data[10:0];
                default: begin
                end
            endcase
        end
    end

    // front: window, frame detect, unpack and check, frame queue
    sfcb_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_rx_byte     (i_rx_byte),
        .o_full        (full),
        .o_frame_valid (frame_valid),
        .o_frame       (frame),
        .i_frame_pop   (frame_pop)
    );

    // back: per-channel scaling, change detect and message build
    sfcb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_frame_valid (frame_valid),
        .i_frame       (frame),
        .o_frame_pop   (frame_pop),
        .i_oq_full     (oq_full),
        .o_oq_push     (oq_push),
        .o_oq_item     (oq_in)
    );

    // result queue decouples the pipe from the consumer
    sfcb_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (oq_push),
        .i_item  (oq_in),
        .o_full  (oq_full),
        .o_empty (empty),
        .o_item  (oq_out),
        .i_pop   (pop),
        .o_count (oq_count)
    );

    assign o_message_id    = oq_out.message_id;
    assign o_payload_high  = oq_out.payload_high;
    assign o_payload_low   = oq_out.payload_low;
    assign o_last_of_frame = oq_out.last_of_frame;

    // a message is never written into a full result queue
    a_no_oq_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        oq_push |-> !oq_full)
        else $error("result queue written while full");

    // the result queue never holds more than its depth
    a_oq_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        oq_count <= (OQ_AW+1)'(OQ_DEPTH))
        else $error("result queue count out of range");

    // the back end only releases a frame that is waiting
    a_frame_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        frame_pop |-> frame_valid)
        else $error("frame released from empty frame queue");

    // a queued item stays in place while the consumer holds it
    a_head_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(oq_out)))
        else $error("waiting result changed before it was taken");

endmodule

FILE: tb/sfcb_message_checker.sv
`timescale 1ns / 1ps
module sfcb_message_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte side
    input  logic        i_push,
    input  logic        i_full,
    input  logic [7:0]  i_rx_byte,
    // message side
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic [10:0] i_message_id,
    input  logic [7:0]  i_payload_high,
    input  logic [7:0]  i_payload_low,
    input  logic        i_last_of_frame,
    // config write channel
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [sfcb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sfcb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // status for the top
    output int          o_fail_count,
    output int          o_waiting,
    output int          o_predicted
);

    import sfcb_pkg::*;

    localparam t_cfg CFG_AT_RESET = '{
        split_threshold: 11'd1000,
        gain_upper:      16'd40878,
        offset_upper:    28'd57425920,
        gain_lower:      16'd41042,
        offset_lower:    28'd57262080,
        message_base_id: 11'd16
    };

    logic [7:0]  window [WINDOW_LEN];
    logic [11:0] sent_value [REPORTED_CHANNELS];
    t_cfg        settings;
    t_msg        pending_messages [$];
    int          mismatches = 0;
    int          predicted = 0;

    function automatic void take_setting(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_SPLIT_THRESHOLD: settings.split_threshold = data[10:0];
            CFG_GAIN_UPPER:      settings.gain_upper      = data[15:0];
            CFG_OFFSET_UPPER:    settings.offset_upper    = data[27:0];
            CFG_GAIN_LOWER:      settings.gain_lower      = data[15:0];
            CFG_OFFSET_LOWER:    settings.offset_lower    = data[27:0];
            CFG_MESSAGE_BASE_ID: settings.message_base_id = data[10:0];
            default: ;
        endcase
    endfunction

    // piecewise-linear scaling, truncated and clipped to the 12-bit state
    function automatic logic [11:0] scaled_value(input t_raw raw);
        logic [31:0] acc;
        if (raw >= settings.split_threshold) begin
            acc = 32'(raw) * 32'(settings.gain_upper) + 32'(settings.offset_upper);
        end else begin
            acc = 32'(raw) * 32'(settings.gain_lower) + 32'(settings.offset_lower);
        end
        acc = acc >> 16;
        return (acc > 32'(STATE_MAX)) ? STATE_MAX : acc[11:0];
    endfunction

    function automatic logic [11:0] switch_value(input t_raw raw);
        logic [11:0] v;
        if (raw == SW_HIGH) begin
            v = MAP_HIGH;
        end else if (raw == SW_MID) begin
            v = MAP_MID;
        end else if (raw == SW_LOW) begin
            v = MAP_LOW;
        end else begin
            v = {1'b0, raw};
        end
        return v;
    endfunction

    // slide one byte in; on a complete frame queue the messages it causes
    function automatic void absorb_byte(input logic [7:0] value);
        t_raw        raw [CHANNEL_COUNT];
        logic [23:0] span;
        int          bit_pos;
        int          at;
        logic [11:0] cmp;
        logic [15:0] pay;
        t_msg        msg;
        t_msg        held;
        bit          have_held;
        for (int i = 0; i < WINDOW_LEN - 1; i++) begin
            window[i] = window[i + 1];
        end
        window[WINDOW_LEN - 1] = value;
        if (window[0] != START_BYTE || window[WINDOW_LEN - 1] != END_BYTE) begin
            return;
        end
        for (int c = 0; c < CHANNEL_COUNT; c++) begin
            bit_pos = RAW_W * c;
            at      = 1 + bit_pos / 8;
            span    = {window[at + 2], window[at + 1], window[at]};
            raw[c]  = t_raw'(span >> (bit_pos % 8));
        end
        for (int i = 0; i < WINDOW_LEN; i++) begin
            window[i] = 8'h00;
        end
        if (!((raw[5] == SW_LOW || raw[5] == SW_HIGH) &&
              (raw[4] == SW_HIGH || raw[4] == SW_MID || raw[4] == SW_LOW) &&
              raw[8] == raw[9] && raw[15] == CH15_REF)) begin
            return;
        end
        have_held = 1'b0;
        for (int c = 0; c < REPORTED_CHANNELS && c < CHANNEL_COUNT; c++) begin
            if (c <= 3 || c == 7) begin
                cmp = scaled_value(raw[c]);
                pay = 16'(cmp);
            end else if (c <= 6) begin
                cmp = {1'b0, raw[c]};
                pay = 16'(switch_value(raw[c]));
            end else begin
                cmp = {1'b0, raw[c]};
                pay = 16'(raw[c]);
            end
            if (cmp != sent_value[c]) begin
                sent_value[c]     = cmp;
                msg.message_id    = settings.message_base_id + 11'(c);
                msg.payload_high  = pay[15:8];
                msg.payload_low   = pay[7:0];
                msg.last_of_frame = 1'b0;
                if (have_held) begin
                    pending_messages.push_back(held);
                end
                held      = msg;
                have_held = 1'b1;
                predicted++;
            end
        end
        if (have_held) begin
            held.last_of_frame = 1'b1;
            pending_messages.push_back(held);
        end
    endfunction

    function automatic void check_message(input t_msg got);
        t_msg want;
        if (pending_messages.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: unexpected item id %0d payload %02h%02h last %0b", $time,
                         got.message_id, got.payload_high, got.payload_low,
                         got.last_of_frame);
            end
        end else begin
            want = pending_messages.pop_front();
            if (got.message_id !== want.message_id ||
                got.payload_high !== want.payload_high ||
                got.payload_low !== want.payload_low ||
                got.last_of_frame !== want.last_of_frame) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: item mismatch, expected id %0d payload %02h%02h last %0b",
                             $time, want.message_id, want.payload_high, want.payload_low,
                             want.last_of_frame);
                    $display("%0t:                got      id %0d payload %02h%02h last %0b",
                             $time, got.message_id, got.payload_high, got.payload_low,
                             got.last_of_frame);
                end
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW_LEN; i++) begin
                window[i] = 8'h00;
            end
            for (int c = 0; c < REPORTED_CHANNELS; c++) begin
                sent_value[c] = 12'h000;
            end
            settings = CFG_AT_RESET;
            pending_messages.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                take_setting(i_cfg_index, i_cfg_data);
            end
            // outgoing item belongs to an older frame, so check before predicting
            if (i_pop && !i_empty) begin
                check_message('{message_id:    i_message_id,
                                payload_high:  i_payload_high,
                                payload_low:   i_payload_low,
                                last_of_frame: i_last_of_frame});
            end
            if (i_push && !i_full) begin
                absorb_byte(i_rx_byte);
            end
        end
        o_fail_count <= mismatches;
        o_waiting    <= pending_messages.size();
        o_predicted  <= predicted;
    end

endmodule

FILE: tb/tb_sbus_frame_to_can_bridge.sv
`timescale 1ns / 1ps
module tb_sbus_frame_to_can_bridge;

    import sfcb_pkg::*;

    typedef t_raw t_chan_set [CHANNEL_COUNT];

    // ways of spoiling an otherwise good frame
    typedef enum int {
        FLAW_CH15,
        FLAW_PAIR,
        FLAW_CH5,
        FLAW_CH4,
        FLAW_CUT
    } t_flaw;

    // indexes with no register behind them, writes must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    // quiet time after the last item: covers silent frames still in the frame queue
    // and the back-end pipe, with margin
    localparam int SETTLE_CYCLES = 30;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push    = 1'b0;
    logic        full;
    logic [7:0]  rx_byte = 8'h00;
    logic        empty;
    logic        pop     = 1'b0;
    logic [10:0] message_id;
    logic [7:0]  payload_high;
    logic [7:0]  payload_low;
    logic        last_of_frame;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int        fail_count;
    int        waiting;
    int        predicted;
    int        bytes_sent = 0;
    bit        no_gaps    = 1'b0;
    t_chan_set last_good;

    sbus_frame_to_can_bridge uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_rx_byte       (rx_byte),
        .empty           (empty),
        .pop             (pop),
        .o_message_id    (message_id),
        .o_payload_high  (payload_high),
        .o_payload_low   (payload_low),
        .o_last_of_frame (last_of_frame),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    // watches all three channels, predicts every message and compares
    sfcb_message_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_full          (full),
        .i_rx_byte       (rx_byte),
        .i_empty         (empty),
        .i_pop           (pop),
        .i_message_id    (message_id),
        .i_payload_high  (payload_high),
        .i_payload_low   (payload_low),
        .i_last_of_frame (last_of_frame),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_waiting       (waiting),
        .o_predicted     (predicted)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // message side: pop held low about a quarter of the time unless in a no-gap stretch
    initial begin
        forever begin
            @(posedge i_clk);
            pop <= no_gaps || ($urandom_range(99) >= 26);
        end
    end

    // hard stop in case the bridge hangs
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // one byte through push/full, with random idle cycles in front of it
    task automatic send_byte(input logic [7:0] value);
        while (!no_gaps && $urandom_range(99) < 26) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push    <= 1'b1;
        rx_byte <= value;
        do @(posedge i_clk); while (full);
        bytes_sent++;
    endtask

    // pack sixteen channels little-endian behind the start byte, flags byte, end byte;
    // only the first n_bytes go out, so a frame can be cut short
    task automatic send_frame(input t_chan_set ch, input int n_bytes);
        logic [8*FRAME_BYTES-1:0] bits;
        logic [7:0]               frame_bytes [WINDOW_LEN];
        bits = '0;
        for (int c = 0; c < CHANNEL_COUNT; c++) begin
            bits[RAW_W*c +: RAW_W] = ch[c];
        end
        frame_bytes[0] = START_BYTE;
        for (int i = 0; i < FRAME_BYTES; i++) begin
            frame_bytes[i + 1] = bits[8*i +: 8];
        end
        frame_bytes[WINDOW_LEN - 2] = 8'($urandom_range(255));
        frame_bytes[WINDOW_LEN - 1] = END_BYTE;
        for (int i = 0; i < n_bytes; i++) begin
            send_byte(frame_bytes[i]);
        end
    endtask

    // channel values lean towards the ends of the range and the default split point
    function automatic t_raw any_raw();
        t_raw v;
        case ($urandom_range(9))
            0:       v = '0;
            1:       v = '1;
            2:       v = t_raw'($urandom_range(990, 1010));
            default: v = t_raw'($urandom_range(2047));
        endcase
        return v;
    endfunction

    function automatic t_raw any_switch();
        t_raw v;
        case ($urandom_range(2))
            0:       v = SW_HIGH;
            1:       v = SW_MID;
            default: v = SW_LOW;
        endcase
        return v;
    endfunction

    // a frame that passes the validity check; some reported channels repeat the
    // previous good frame so that unchanged channels stay silent
    function automatic void make_good_frame(output t_chan_set ch);
        for (int c = 0; c < CHANNEL_COUNT; c++) begin
            ch[c] = any_raw();
        end
        ch[4]  = any_switch();
        ch[5]  = ($urandom_range(1) == 0) ? SW_LOW : SW_HIGH;
        ch[6]  = ($urandom_range(9) < 6) ? any_switch() : any_raw();
        ch[9]  = ch[8];
        ch[15] = CH15_REF;
        for (int c = 0; c < REPORTED_CHANNELS; c++) begin
            if ($urandom_range(9) < 3) begin
                ch[c] = last_good[c];
            end
        end
    endfunction

    // mostly good frames, some spoilt or cut-off ones, some loose bytes that
    // favour the start and end markers
    task automatic random_sequence();
        t_chan_set  ch;
        t_flaw      flaw;
        t_raw       flip;
        logic [7:0] b;
        int         pick;
        pick = $urandom_range(99);
        flip = t_raw'(11'd1 << $urandom_range(RAW_W - 1));
        if (pick < 70) begin
            make_good_frame(ch);
            last_good = ch;
            send_frame(ch, WINDOW_LEN);
        end else if (pick < 85) begin
            make_good_frame(ch);
            flaw = t_flaw'($urandom_range(4));
            case (flaw)
                FLAW_CH15: ch[15] = ch[15] ^ flip;
                FLAW_PAIR: ch[9]  = ch[9] ^ flip;
                FLAW_CH5:  ch[5]  = ch[5] ^ flip;
                FLAW_CH4:  ch[4]  = ch[4] ^ flip;
                default: ;
            endcase
            send_frame(ch, (flaw == FLAW_CUT) ? $urandom_range(1, WINDOW_LEN - 1)
                                              : WINDOW_LEN);
        end else begin
            repeat ($urandom_range(1, 12)) begin
                case ($urandom_range(3))
                    0:       b = START_BYTE;
                    1:       b = END_BYTE;
                    default: b = 8'($urandom_range(255));
                endcase
                send_byte(b);
            end
        end
    endtask

    // random traffic until enough bytes and enough predicted messages have gone by
    task automatic random_phase(input int min_bytes, input int min_msgs);
        int start_bytes;
        int start_msgs;
        start_bytes = bytes_sent;
        start_msgs  = predicted;
        while (bytes_sent - start_bytes < min_bytes || predicted - start_msgs < min_msgs) begin
            random_sequence();
        end
    endtask

    // stop pushing, let every expected item drain, then give the back end time to
    // finish a frame that caused nothing
    task automatic settle();
        push <= 1'b0;
        @(posedge i_clk);
        while (waiting != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // leaves valid high so back-to-back writes need no gap
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!cfg_ready);
    endtask

    // every register, with junk above each field's width, plus the unused indexes
    task automatic load_settings(input logic [10:0] split, input logic [15:0] g_up,
                                 input logic [27:0] o_up, input logic [15:0] g_lo,
                                 input logic [27:0] o_lo, input logic [10:0] base);
        cfg_write(CFG_SPLIT_THRESHOLD, {17'($urandom), split});
        cfg_write(CFG_GAIN_UPPER,      {12'($urandom), g_up});
        cfg_write(CFG_OFFSET_UPPER,    o_up);
        cfg_write(CFG_GAIN_LOWER,      {12'($urandom), g_lo});
        cfg_write(CFG_OFFSET_LOWER,    o_lo);
        cfg_write(CFG_MESSAGE_BASE_ID, {17'($urandom), base});
        cfg_write(CFG_SPARE_A,         28'($urandom));
        cfg_write(CFG_SPARE_B,         '1);
        cfg_valid <= 1'b0;
    endtask

    // hand-picked frames under the reset settings
    task automatic run_directed();
        t_chan_set ch;
        ch = '{default: '0};
        // every reported channel leaves zero: range ends, both sides of the split,
        // an unmapped value on a switch channel
        ch[0] = 11'd0;
        ch[1] = 11'h7FF;
        ch[2] = 11'd999;
        ch[3] = 11'd1000;
        ch[4] = SW_HIGH;
        ch[5] = SW_LOW;
        ch[6] = 11'h7FF;
        ch[7] = 11'd1500;
        for (int c = 10; c < 15; c++) begin
            ch[c] = 11'h7FF;
        end
        ch[15] = CH15_REF;
        send_frame(ch, WINDOW_LEN);
        // scaled channels repeat and stay silent; remaining switch positions,
        // so the frame ends on a middle channel
        ch[4] = SW_MID;
        ch[5] = SW_HIGH;
        ch[6] = SW_LOW;
        send_frame(ch, WINDOW_LEN);
        last_good = ch;
        // channels 8 and 9 disagree: no item, window still cleared
        ch[0] = 11'd77;
        ch[9] = ch[8] ^ 11'h400;
        send_frame(ch, WINDOW_LEN);
    endtask

    initial begin
        // synchronous reset first, then release
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        // upper segment everywhere and saturated, identifiers wrap past 2047
        settle();
        load_settings(11'd0, 16'hFFFF, 28'hFFFFFFF, 16'h0000, 28'h0000000, 11'd2045);
        random_phase(20, 1);

        // lower segment almost everywhere, zero base; a long run with no idling
        settle();
        no_gaps = 1'b1;
        load_settings(11'h7FF, 16'h0000, 28'h0000000, 16'hFFFF, 28'h0000000, 11'd0);
        random_phase(40, 1);
        no_gaps = 1'b0;

        // arbitrary settings
        settle();
        load_settings(11'($urandom_range(2047)), 16'($urandom), 28'($urandom),
                      16'($urandom), 28'($urandom), 11'($urandom_range(2047)));
        random_phase(20, 1);

        settle();
        if (fail_count == 0 && waiting == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/sfcb_pkg.sv
rtl/core/sfcb_front.sv
rtl/core/sfcb_back.sv
rtl/core/sfcb_out_queue.sv
rtl/core/sbus_frame_to_can_bridge.sv
tb/sfcb_message_checker.sv
tb/tb_sbus_frame_to_can_bridge.sv
